[rtl/core/gcd_pkg.sv]
// Grid coverage downsampler package: payload structs, register indexes,
// fixed field widths and the controller state type. No dependencies.
`default_nettype none
package gcd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SIDE_CFG_W  = 13;
  localparam int COV_FRAC    = 16;
  localparam int COV_W       = 17;
  localparam int CELL_IDX_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND   = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] cell_row;
    logic [CELL_IDX_W-1:0] cell_col;
    logic [COV_W-1:0]      coverage;
    logic                  frame_done;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_COV_GO,
    S_COV_WAIT,
    S_COL_GO,
    S_COL_WAIT,
    S_ROW_GO,
    S_ROW_WAIT
  } state_t;

endpackage
`default_nettype wire

[rtl/core/grid_coverage_downsampler.sv]
// Grid coverage downsampler, top level.
// Pixels are taken one at a time: a count read on accept, then a write back. A pixel ending
// a column span adds a column-end step, and a row-end step if it also ends the last line of a row span.
// A cell's closing pixel starts the divider, and its result is registered once the divider
// is done; a result still waiting when the next cell closes stalls input. Reset or any
// register write restarts the frame and recomputes the first cell ends.
`default_nettype none
module grid_coverage_downsampler #(
  parameter int GRID_COLS = 28,
  parameter int GRID_ROWS = 28,
  parameter int MAX_SIDE  = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pixel_valid,
  output logic                               pixel_ready,
  input  wire gcd_pkg::pixel_t               pixel,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output gcd_pkg::result_t                   result,
  input  wire logic                          cfg_wr_en,
  input  wire logic [gcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [gcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gcd_pkg::*;

  // widths derived from the grid and side limits
  localparam int GMAX  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int XW    = $clog2(MAX_SIDE);
  localparam int LW    = $clog2(MAX_SIDE + 1);
  localparam int CIW   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RIW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int GW    = $clog2(GMAX + 1);
  localparam int CELLW = (MAX_SIDE + GRID_COLS - 1) / GRID_COLS + 1;
  localparam int CELLH = (MAX_SIDE + GRID_ROWS - 1) / GRID_ROWS + 1;
  localparam int CW    = $clog2(CELLW * CELLH + 1);
  localparam int ENDW  = $clog2(2 * GMAX * MAX_SIDE + GMAX + 1);
  localparam int DW    = (ENDW > CW + COV_FRAC) ? ENDW : CW + COV_FRAC;
  localparam int VWE   = $clog2(2 * GMAX + 1);
  localparam int VW    = (VWE > CW) ? VWE : CW;

  // configuration registers
  logic [SIDE_CFG_W-1:0] image_width;
  logic [SIDE_CFG_W-1:0] image_height;
  logic [31:0]           background_rgba;
  logic                  restart;

  assign restart = cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH ||
                   cfg_index == CFG_IMAGE_HEIGHT || cfg_index == CFG_BACKGROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= SIDE_CFG_W'(1250);
      image_height    <= SIDE_CFG_W'(1250);
      background_rgba <= 32'd1723858943;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width     <= cfg_data[SIDE_CFG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height    <= cfg_data[SIDE_CFG_W-1:0];
        CFG_BACKGROUND:   background_rgba <= cfg_data;
        default:          ;
      endcase
    end
  end

  // effective sides, clamped so no cell is empty
  logic [31:0]   w_raw, h_raw;
  logic [LW-1:0] eff_w, eff_h;

  assign w_raw = 32'(image_width);
  assign h_raw = 32'(image_height);
  assign eff_w = (w_raw < 32'(GRID_COLS)) ? LW'(GRID_COLS) :
                 (w_raw > 32'(MAX_SIDE))  ? LW'(MAX_SIDE)  : LW'(w_raw);
  assign eff_h = (h_raw < 32'(GRID_ROWS)) ? LW'(GRID_ROWS) :
                 (h_raw > 32'(MAX_SIDE))  ? LW'(MAX_SIDE)  : LW'(h_raw);

  // position state
  state_t         state, state_next;
  logic [XW-1:0]  pixel_x, pixel_y;
  logic [CIW-1:0] column_index;
  logic [RIW-1:0] row_index;
  logic [LW-1:0]  column_end, row_end;
  logic           need_row, need_col, cell_done;
  logic           marked;

  // count memory: {marked, total} per grid column
  logic [2*CW-1:0] rd_data, wr_data;
  logic            mem_rd, mem_wr;
  logic [CW-1:0]   cur_marked, cur_total, new_marked, new_total;
  logic [CW-1:0]   cov_marked, cov_total;

  gcd_count_mem #(
    .DEPTH(GRID_COLS),
    .AW   (CIW),
    .DW   (2 * CW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .clear  (restart),
    .rd_en  (mem_rd),
    .rd_addr(column_index),
    .rd_data(rd_data),
    .wr_en  (mem_wr),
    .wr_addr(column_index),
    .wr_data(wr_data)
  );

  assign cur_marked = rd_data[2*CW-1:CW];
  assign cur_total  = rd_data[CW-1:0];
  assign new_marked = cur_marked + CW'(marked);
  assign new_total  = cur_total + 1'b1;

  // step decisions, evaluated in the update cycle
  logic [LW-1:0] x1, y1;
  logic          hit_col, hit_row, col_adv, wrap_x, row_adv, wrap_y;

  assign x1        = LW'(pixel_x) + 1'b1;
  assign y1        = LW'(pixel_y) + 1'b1;
  assign hit_col   = (x1 == column_end);
  assign hit_row   = (y1 == row_end);
  assign col_adv   = (x1 >= column_end);
  assign wrap_x    = col_adv && (x1 >= eff_w || column_index == CIW'(GRID_COLS - 1));
  assign row_adv   = (y1 >= row_end);
  assign wrap_y    = (y1 >= eff_h) || (row_index == RIW'(GRID_ROWS - 1));
  assign cell_done = hit_col && hit_row;

  assign wr_data = cell_done ? '0 : {new_marked, new_total};

  // serial divider for coverage = (marked << 16) / total
  logic                  div_start, div_busy;
  logic [DW-1:0]         div_dividend, div_quotient;
  logic [VW-1:0]         div_divisor;
  logic [GW-1:0]         g1;
  logic [LW-1:0]         axis_len;
  logic [GW+LW-1:0]      prod;
  logic                  row_axis;

  assign div_dividend = DW'({cov_marked, {COV_FRAC{1'b0}}});
  assign div_divisor  = VW'(cov_total);

  gcd_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(div_quotient)
  );

  // cell ends: num = 2*(g+1)*len + cells is registered in the GO cycle, then divided
  // by the constant 2*cells in the WAIT cycle with a rounded-up reciprocal; RS makes
  // the reciprocal exact for every numerator below 2**ENDW
  localparam int            RS        = ENDW + VWE;
  localparam longint        RECIP_ONE = longint'(1) << RS;
  localparam logic [RS-1:0] COL_RECIP =
    RS'((RECIP_ONE + 2 * GRID_COLS - 1) / (2 * GRID_COLS));
  localparam logic [RS-1:0] ROW_RECIP =
    RS'((RECIP_ONE + 2 * GRID_ROWS - 1) / (2 * GRID_ROWS));

  logic [ENDW-1:0]    end_num;
  logic [RS-1:0]      end_recip;
  logic [ENDW+RS-1:0] end_prod;

  assign row_axis  = (state == S_ROW_GO);
  assign g1        = row_axis ? GW'(row_index) + 1'b1 : GW'(column_index) + 1'b1;
  assign axis_len  = row_axis ? eff_h : eff_w;
  assign prod      = g1 * axis_len;
  assign end_recip = (state == S_ROW_WAIT) ? ROW_RECIP : COL_RECIP;
  assign end_prod  = (ENDW+RS)'(end_num) * (ENDW+RS)'(end_recip);

  always_ff @(posedge clk) begin
    if (state == S_COL_GO || state == S_ROW_GO) begin
      end_num <= ENDW'({prod, 1'b0}) + ENDW'(row_axis ? GRID_ROWS : GRID_COLS);
    end
  end

  // controller
  logic out_free;
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= S_COL_GO;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pixel_ready = 1'b0;
    mem_rd      = 1'b0;
    mem_wr      = 1'b0;
    div_start   = 1'b0;
    case (state)
      S_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          mem_rd     = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        mem_wr = 1'b1;
        if (cell_done) begin
          state_next = S_COV_GO;
        end else if (col_adv) begin
          state_next = S_COL_GO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_COV_GO: begin
        div_start  = 1'b1;
        state_next = S_COV_WAIT;
      end
      S_COV_WAIT: begin
        if (!div_busy && out_free) begin
          state_next = need_col ? S_COL_GO : S_IDLE;
        end
      end
      S_COL_GO: begin
        state_next = S_COL_WAIT;
      end
      S_COL_WAIT: begin
        state_next = need_row ? S_ROW_GO : S_IDLE;
      end
      S_ROW_GO: begin
        state_next = S_ROW_WAIT;
      end
      S_ROW_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // position and cell-end registers
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_x      <= '0;
      pixel_y      <= '0;
      column_index <= '0;
      row_index    <= '0;
      need_col     <= 1'b1;
      need_row     <= 1'b1;
    end else begin
      case (state)
        S_UPDATE: begin
          need_col <= col_adv;
          need_row <= wrap_x && row_adv;
          if (!col_adv) begin
            pixel_x <= pixel_x + 1'b1;
          end else if (wrap_x) begin
            pixel_x      <= '0;
            column_index <= '0;
            if (!row_adv) begin
              pixel_y <= pixel_y + 1'b1;
            end else if (wrap_y) begin
              pixel_y   <= '0;
              row_index <= '0;
            end else begin
              pixel_y   <= pixel_y + 1'b1;
              row_index <= row_index + 1'b1;
            end
          end else begin
            pixel_x      <= pixel_x + 1'b1;
            column_index <= column_index + 1'b1;
          end
        end
        S_COL_WAIT: begin
          column_end <= end_prod[RS +: LW];
        end
        S_ROW_WAIT: begin
          row_end <= end_prod[RS +: LW];
        end
        default: ;
      endcase
    end
  end

  // pixel compare on accept, cell snapshot on update
  logic [CELL_IDX_W-1:0] snap_row, snap_col;
  logic                  snap_fd;

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      marked <= ({pixel.red, pixel.green, pixel.blue, pixel.alpha} != background_rgba);
    end
    if (state == S_UPDATE) begin
      cov_marked <= new_marked;
      cov_total  <= new_total;
      snap_row   <= CELL_IDX_W'(row_index);
      snap_col   <= CELL_IDX_W'(column_index);
      snap_fd    <= (row_index == RIW'(GRID_ROWS - 1)) &&
                    (column_index == CIW'(GRID_COLS - 1));
    end
  end

  // result register; a result still waiting when the next cell closes
  // holds the controller in S_COV_WAIT, which stalls pixel intake
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_COV_WAIT && !div_busy && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COV_WAIT && !div_busy && out_free) begin
      result.cell_row   <= snap_row;
      result.cell_col   <= snap_col;
      result.coverage   <= COV_W'(div_quotient);
      result.frame_done <= snap_fd;
    end
  end

endmodule
`default_nettype wire

[rtl/core/gcd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Self-contained; no package or submodule dependencies.
`default_nettype none
module gcd_div #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic [DW-1:0]      quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(DW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      // shift in one quotient bit, dividend bits shift out the top
      rem      <= fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[rtl/core/gcd_count_mem.sv]
// Per-column count memory: one write port, one registered read port.
// Entry valid bits make unwritten or cleared entries read as zero.
`default_nettype none
module gcd_count_mem #(
  parameter int DEPTH = 28,
  parameter int AW    = 5,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);
  import gcd_pkg::*;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    raw;
  logic             raw_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld     <= '0;
      raw_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        raw_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = raw_vld ? raw : '0;

endmodule
`default_nettype wire
